// File: sv/ltfl_pkg.sv
// ============================================================================
// ltfl_pkg - shared types and constants of the linked table
// Field widths, operation and status codes, the command carried between the
// front and back parts, and the state encoding of the back part.
// ============================================================================
`default_nettype none

package ltfl_pkg;

   // Field widths of the request and response channels
   localparam int KEY_W      = 64;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 5;

   // At most this many responses for one walk
   localparam int WALK_MAX   = 16;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request kind codes
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WALK   = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_REMOVE,
      OP_WALK
   } ltfl_op_type;

   typedef struct packed {
      ltfl_op_type      op;
      logic [KEY_W-1:0] key_high;
      logic [KEY_W-1:0] key_low;
   } ltfl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ltfl_queue_stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_FULL,
      S_ADD_WR,
      S_RM_CMP,
      S_RM_UNLINK,
      S_RM_FREE,
      S_RM_MISS,
      S_WK_OUT,
      S_WK_EMPTY
   } ltfl_state_type;

endpackage

`default_nettype wire

// File: sv/ltfl_front.sv
// ============================================================================
// ltfl_front - request intake
// Accepts requests while the command queue has room, decodes the kind into
// an operation and drops the unused kind without passing it on.
// ============================================================================
`default_nettype none

module ltfl_front (
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [ltfl_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [ltfl_pkg::KEY_W-1:0]   req_key_high,
   input  wire logic [ltfl_pkg::KEY_W-1:0]   req_key_low,
   input  wire ltfl_pkg::ltfl_queue_stat_type q_stat,
   output logic                              q_push,
   output ltfl_pkg::ltfl_cmd_type            q_push_cmd
);
   import ltfl_pkg::*;

   logic known_kind;

   // Take a request whenever the queue can hold it
   assign req_ready = !q_stat.full;

   // Decode the kind; an unused kind is consumed and dropped
   always_comb begin
      known_kind          = 1'b1;
      q_push_cmd.op       = OP_ADD;
      q_push_cmd.key_high = req_key_high;
      q_push_cmd.key_low  = req_key_low;
      case (req_kind)
         KIND_ADD:    q_push_cmd.op = OP_ADD;
         KIND_REMOVE: q_push_cmd.op = OP_REMOVE;
         KIND_WALK:   q_push_cmd.op = OP_WALK;
         default:     known_kind    = 1'b0;
      endcase
   end

   assign q_push = req_valid && req_ready && known_kind;

endmodule

`default_nettype wire

// File: sv/ltfl_queue.sv
// ============================================================================
// ltfl_queue - command queue
// Short first-in first-out buffer between intake and execution, so that each
// side stalls on its own.
// ============================================================================
`default_nettype none

module ltfl_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ltfl_pkg::ltfl_cmd_type push_cmd,
   input  wire logic                   pop,
   output ltfl_pkg::ltfl_cmd_type      head_cmd,
   output ltfl_pkg::ltfl_queue_stat_type stat
);
   import ltfl_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   ltfl_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign stat.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign stat.empty = (fill_ff == '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: sv/ltfl_back.sv
// ============================================================================
// ltfl_back - list engine
// Executes add, remove and walk commands on the slot pool: key and link
// memories with one registered read port, the list and free heads, the entry
// count and the response register.
// ============================================================================
`default_nettype none

module ltfl_back #(
   parameter int ENTRIES = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ltfl_pkg::ltfl_queue_stat_type   q_stat,
   input  wire ltfl_pkg::ltfl_cmd_type          q_head,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [ltfl_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ltfl_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [ltfl_pkg::KEY_W-1:0]           rsp_entry_high,
   output logic [ltfl_pkg::KEY_W-1:0]           rsp_entry_low,
   output logic [ltfl_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                 rsp_last
);
   import ltfl_pkg::*;

   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LINK_W     = $clog2(ENTRIES + 1);
   localparam int WALK_LIMIT = (ENTRIES < WALK_MAX) ? ENTRIES : WALK_MAX;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

   // Memories
   logic [KEY_W-1:0]  key_hi_mem [ENTRIES];
   logic [KEY_W-1:0]  key_lo_mem [ENTRIES];
   logic [LINK_W-1:0] link_mem   [ENTRIES];
   logic [ENTRIES-1:0] link_vld_ff;

   // Registered read data
   logic [KEY_W-1:0]  key_hi_rd_ff;
   logic [KEY_W-1:0]  key_lo_rd_ff;
   logic [LINK_W-1:0] link_rd_ff;

   // Control state
   ltfl_state_type    state_ff, state_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] steps_ff, steps_in;
   logic [LINK_W-1:0] list_head_ff, list_head_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in;
   logic [LINK_W-1:0] count_ff, count_in;
   ltfl_cmd_type      cmd_ff, cmd_in;

   // Memory controls
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              key_we;
   logic [IDX_W-1:0]  key_waddr;
   logic              link_we;
   logic [IDX_W-1:0]  link_waddr;
   logic [LINK_W-1:0] link_wdata;

   // Response build
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [KEY_W-1:0]    rsp_entry_high_ff;
   logic [KEY_W-1:0]    rsp_entry_low_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;
   logic                out_free;
   logic                emit;
   logic [STATUS_W-1:0] res_status;
   logic [SLOT_W-1:0]   res_slot;
   logic [KEY_W-1:0]    res_high;
   logic [KEY_W-1:0]    res_low;
   logic                res_last;
   logic                key_match;
   logic                walk_fin;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign key_match = (key_hi_rd_ff == cmd_ff.key_high) && (key_lo_rd_ff == cmd_ff.key_low);
   assign walk_fin  = (link_rd_ff >= NULL_LINK) ||
                      (steps_ff + LINK_W'(1) >= LINK_W'(WALK_LIMIT));

   // Next state, memory controls and response contents
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = free_head_ff[IDX_W-1:0];
      key_we       = 1'b0;
      key_waddr    = free_head_ff[IDX_W-1:0];
      link_we      = 1'b0;
      link_waddr   = cur_ff[IDX_W-1:0];
      link_wdata   = free_head_ff;
      emit         = 1'b0;
      res_status   = STATUS_OK;
      res_slot     = '0;
      res_high     = '0;
      res_low      = '0;
      res_last     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               case (q_head.op)
                  OP_ADD: begin
                     // Pop the free head: store the key, fetch its link
                     if (free_head_ff >= NULL_LINK) begin
                        state_in = S_ADD_FULL;
                     end else begin
                        rd_en    = 1'b1;
                        key_we   = 1'b1;
                        state_in = S_ADD_WR;
                     end
                  end
                  OP_REMOVE: begin
                     cur_in   = list_head_ff;
                     prev_in  = NULL_LINK;
                     steps_in = '0;
                     if (list_head_ff >= NULL_LINK) begin
                        state_in = S_RM_MISS;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = list_head_ff[IDX_W-1:0];
                        state_in = S_RM_CMP;
                     end
                  end
                  OP_WALK: begin
                     cur_in   = list_head_ff;
                     steps_in = '0;
                     if (list_head_ff >= NULL_LINK) begin
                        state_in = S_WK_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = list_head_ff[IDX_W-1:0];
                        state_in = S_WK_OUT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_FULL: begin
            if (out_free) begin
               emit       = 1'b1;
               res_status = STATUS_FULL;
               state_in   = S_IDLE;
            end
         end
         S_ADD_WR: begin
            // Push the new slot at the list head
            if (out_free) begin
               emit         = 1'b1;
               res_slot     = SLOT_W'(free_head_ff);
               res_high     = cmd_ff.key_high;
               res_low      = cmd_ff.key_low;
               link_we      = 1'b1;
               link_waddr   = free_head_ff[IDX_W-1:0];
               link_wdata   = list_head_ff;
               list_head_in = free_head_ff;
               free_head_in = link_rd_ff;
               count_in     = count_ff + LINK_W'(1);
               state_in     = S_IDLE;
            end
         end
         S_RM_CMP: begin
            // Compare the fetched key, else follow the link
            if (key_match) begin
               state_in = S_RM_UNLINK;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rd_ff;
               steps_in = steps_ff + LINK_W'(1);
               if ((link_rd_ff >= NULL_LINK) ||
                   (steps_ff + LINK_W'(1) >= LINK_W'(ENTRIES))) begin
                  state_in = S_RM_MISS;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = link_rd_ff[IDX_W-1:0];
               end
            end
         end
         S_RM_UNLINK: begin
            // Bridge the predecessor over the matched slot
            if (prev_ff < NULL_LINK) begin
               link_we    = 1'b1;
               link_waddr = prev_ff[IDX_W-1:0];
               link_wdata = link_rd_ff;
            end
            state_in = S_RM_FREE;
         end
         S_RM_FREE: begin
            // Push the matched slot on the free list
            if (out_free) begin
               emit         = 1'b1;
               res_slot     = SLOT_W'(cur_ff);
               res_high     = key_hi_rd_ff;
               res_low      = key_lo_rd_ff;
               link_we      = 1'b1;
               link_waddr   = cur_ff[IDX_W-1:0];
               link_wdata   = free_head_ff;
               free_head_in = cur_ff;
               // A match at the head moves the list head past it
               if (prev_ff >= NULL_LINK) begin
                  list_head_in = link_rd_ff;
               end
               if (count_ff != '0) begin
                  count_in = count_ff - LINK_W'(1);
               end
               state_in     = S_IDLE;
            end
         end
         S_RM_MISS: begin
            if (out_free) begin
               emit       = 1'b1;
               res_status = STATUS_NOT_FOUND;
               state_in   = S_IDLE;
            end
         end
         S_WK_OUT: begin
            // Emit the fetched entry and fetch the next one
            if (out_free) begin
               emit     = 1'b1;
               res_slot = SLOT_W'(cur_ff);
               res_high = key_hi_rd_ff;
               res_low  = key_lo_rd_ff;
               res_last = walk_fin;
               if (walk_fin) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = link_rd_ff[IDX_W-1:0];
                  cur_in   = link_rd_ff;
                  steps_in = steps_ff + LINK_W'(1);
               end
            end
         end
         S_WK_EMPTY: begin
            if (out_free) begin
               emit       = 1'b1;
               res_status = STATUS_EMPTY;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= NULL_LINK;
         prev_ff      <= NULL_LINK;
         steps_ff     <= '0;
         list_head_ff <= NULL_LINK;
         free_head_ff <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         steps_ff     <= steps_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
      end
   end

   // Hold the command under execution
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   // Key memories
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_hi_mem[key_waddr] <= q_head.key_high;
         key_lo_mem[key_waddr] <= q_head.key_low;
      end
   end

   // Link memory; an unwritten slot links to the next one
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (link_we) begin
         link_vld_ff[link_waddr] <= 1'b1;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_hi_rd_ff <= key_hi_mem[rd_addr];
         key_lo_rd_ff <= key_lo_mem[rd_addr];
         link_rd_ff   <= link_vld_ff[rd_addr] ? link_mem[rd_addr]
                                              : (LINK_W'(rd_addr) + LINK_W'(1));
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff     <= res_status;
         rsp_slot_ff       <= res_slot;
         rsp_entry_high_ff <= res_high;
         rsp_entry_low_ff  <= res_low;
         rsp_count_ff      <= COUNT_W'(count_in);
         rsp_last_ff       <= res_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_entry_high = rsp_entry_high_ff;
   assign rsp_entry_low  = rsp_entry_low_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LINK_W'(ENTRIES))
      else $error("entry count above pool size");

   a_free_empty_full: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff >= NULL_LINK) |-> (count_ff == LINK_W'(ENTRIES)))
      else $error("free list empty while pool not full");

   a_list_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (list_head_ff >= NULL_LINK) |-> (count_ff == '0))
      else $error("list empty while count non-zero");

   a_walk_slot_real: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WK_OUT || state_ff == S_RM_CMP) |-> (cur_ff < NULL_LINK))
      else $error("traversal on a null link");

endmodule

`default_nettype wire

// File: sv/linked_table_with_free_list_core.sv
// ============================================================================
// linked_table_with_free_list_core - linked key table with free list
// Pool of ENTRIES slots holding 128-bit keys, threaded as an in-use list and
// a free list; supports add, remove by key and an ordered walk.
// ============================================================================
//
//   channel  direction  handshake              contents
//   req_     in         req_valid / req_ready  kind, key_high, key_low
//   rsp_     out        rsp_valid / rsp_ready  status, slot, entry_high/low,
//                                              count, last
//
// Add reaches the response register through S_ADD_WR, a full table through
// S_ADD_FULL. Remove visits S_RM_CMP once per slot compared (at most
// ENTRIES), then S_RM_UNLINK and S_RM_FREE; a miss goes to S_RM_MISS. Walk
// gives one response per cycle while rsp_ready does not stall it; the single
// read port of the key and link memories sets the one-slot-per-cycle
// traversal. Reset clears the heads, the count and the link valid bits.
// A stalled rsp_ready holds the engine; the two-entry command queue keeps
// taking requests meanwhile. An unused kind is accepted and dropped.
// ============================================================================
`default_nettype none

module linked_table_with_free_list_core #(
   parameter int ENTRIES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ltfl_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [ltfl_pkg::KEY_W-1:0]    req_key_high,
   input  wire logic [ltfl_pkg::KEY_W-1:0]    req_key_low,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ltfl_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ltfl_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [ltfl_pkg::KEY_W-1:0]         rsp_entry_high,
   output logic [ltfl_pkg::KEY_W-1:0]         rsp_entry_low,
   output logic [ltfl_pkg::COUNT_W-1:0]       rsp_count,
   output logic                               rsp_last
);
   import ltfl_pkg::*;

   ltfl_queue_stat_type q_stat;
   ltfl_cmd_type        q_push_cmd;
   ltfl_cmd_type        q_head;
   logic                q_push;
   logic                q_pop;

   // Intake and decode
   ltfl_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_key_high (req_key_high),
      .req_key_low  (req_key_low),
      .q_stat       (q_stat),
      .q_push       (q_push),
      .q_push_cmd   (q_push_cmd)
   );

   // Command queue
   ltfl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .stat     (q_stat)
   );

   // List engine
   ltfl_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_stat         (q_stat),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_entry_high (rsp_entry_high),
      .rsp_entry_low  (rsp_entry_low),
      .rsp_count      (rsp_count),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - linked key table with free list, self-checking bench
// Drives add, remove and walk requests into the table and checks every
// response against an in-bench model of the slot pool and its two lists.
// A short directed table covers the empty, full and miss corners, then
// random traffic alternates fill and drain phases with idling on both sides.
// ============================================================================

module tb_top;
   import ltfl_pkg::*;

   localparam int         SLOTS       = 16;
   localparam logic [4:0] NO_LINK     = 5'd16;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         RANDOM_ITEMS = 195;
   localparam int         CYCLE_LIMIT  = 600000;
   localparam logic [63:0] ONES       = '1;
   localparam logic [63:0] FILL_HI    = 64'h5a5a_0000_0000_0000;
   localparam logic [63:0] FILL_LO    = 64'ha5a5_ffff_ffff_ffff;
   localparam logic [63:0] MISS_HI    = 64'h0123_4567_89ab_cdef;
   localparam logic [63:0] MISS_LO    = 64'hfedc_ba98_7654_3210;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [KEY_W-1:0]    entry_high;
      logic [KEY_W-1:0]    entry_low;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } table_rsp_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      int                reps;
      bit                typed;
      table_rsp_type     want;
   } dir_row_type;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind     = '0;
   logic [KEY_W-1:0]    req_key_high = '0;
   logic [KEY_W-1:0]    req_key_low  = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [KEY_W-1:0]    rsp_entry_high;
   logic [KEY_W-1:0]    rsp_entry_low;
   logic [COUNT_W-1:0]  rsp_count;
   logic                rsp_last;

   // typed expectation travelling with the request payload
   bit                  drv_typed    = 1'b0;
   table_rsp_type       drv_want     = '0;
   bit                  no_gaps      = 1'b0;

   // model of the slot pool
   logic [KEY_W-1:0]    key_hi_m [SLOTS];
   logic [KEY_W-1:0]    key_lo_m [SLOTS];
   logic [4:0]          link_m   [SLOTS];
   logic [4:0]          head_m;
   logic [4:0]          free_m;
   logic [4:0]          count_m;
   table_rsp_type       step_rsp [WALK_MAX];

   table_rsp_type       rsp_due [$];
   int                  fail_cnt  = 0;
   int                  cycle_cnt = 0;
   int                  ready_run = 0;
   int                  n_add = 0, n_remove = 0, n_walk = 0, n_unused = 0, n_rsp = 0;
   int                  n_full = 0, n_miss = 0, n_empty = 0;

   linked_table_with_free_list_core #(
      .ENTRIES (SLOTS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_key_high   (req_key_high),
      .req_key_low    (req_key_low),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_entry_high (rsp_entry_high),
      .rsp_entry_low  (rsp_entry_low),
      .rsp_count      (rsp_count),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic table_rsp_type entry_rsp(input logic [STATUS_W-1:0] status,
                                               input logic [SLOT_W-1:0] slot,
                                               input logic [KEY_W-1:0] hi,
                                               input logic [KEY_W-1:0] lo,
                                               input logic [COUNT_W-1:0] count,
                                               input logic last);
      table_rsp_type r;
      r.status     = status;
      r.slot       = slot;
      r.entry_high = hi;
      r.entry_low  = lo;
      r.count      = count;
      r.last       = last;
      return r;
   endfunction

   // Apply one request to the pool model; fill step_rsp, return response count
   function automatic int apply_table_op(input logic [KIND_W-1:0] kind,
                                         input logic [KEY_W-1:0] hi,
                                         input logic [KEY_W-1:0] lo);
      logic [4:0] cur, prev, nxt;
      int         steps, n;
      bit         found, fin;
      n = 0;
      steps = 0;
      case (kind)
         KIND_ADD: begin
            if (free_m >= NO_LINK) begin
               step_rsp[0] = entry_rsp(STATUS_FULL, '0, '0, '0, count_m, 1'b1);
            end else begin
               // pop the free head, push it on the list head
               cur = free_m;
               key_hi_m[cur[3:0]] = hi;
               key_lo_m[cur[3:0]] = lo;
               free_m = link_m[cur[3:0]];
               link_m[cur[3:0]] = head_m;
               head_m = cur;
               count_m = count_m + 1'b1;
               step_rsp[0] = entry_rsp(STATUS_OK, cur[3:0], hi, lo, count_m, 1'b1);
            end
            n = 1;
         end
         KIND_REMOVE: begin
            cur = head_m;
            prev = NO_LINK;
            found = 1'b0;
            while (!found && cur < NO_LINK && steps < SLOTS) begin
               if (key_hi_m[cur[3:0]] == hi && key_lo_m[cur[3:0]] == lo) begin
                  found = 1'b1;
               end else begin
                  prev = cur;
                  cur = link_m[cur[3:0]];
                  steps++;
               end
            end
            if (!found) begin
               step_rsp[0] = entry_rsp(STATUS_NOT_FOUND, '0, '0, '0, count_m, 1'b1);
            end else begin
               // unlink the first match and return it to the free list
               if (prev >= NO_LINK) head_m = link_m[cur[3:0]];
               else link_m[prev[3:0]] = link_m[cur[3:0]];
               link_m[cur[3:0]] = free_m;
               free_m = cur;
               if (count_m != 0) count_m = count_m - 1'b1;
               step_rsp[0] = entry_rsp(STATUS_OK, cur[3:0], key_hi_m[cur[3:0]],
                                       key_lo_m[cur[3:0]], count_m, 1'b1);
            end
            n = 1;
         end
         KIND_WALK: begin
            cur = head_m;
            if (cur >= NO_LINK) begin
               step_rsp[0] = entry_rsp(STATUS_EMPTY, '0, '0, '0, count_m, 1'b1);
               n = 1;
            end else begin
               while (cur < NO_LINK && steps < SLOTS && n < WALK_MAX) begin
                  nxt = link_m[cur[3:0]];
                  fin = (nxt >= NO_LINK) || (steps + 1 >= SLOTS) || (n + 1 >= WALK_MAX);
                  step_rsp[n] = entry_rsp(STATUS_OK, cur[3:0], key_hi_m[cur[3:0]],
                                          key_lo_m[cur[3:0]], count_m, fin);
                  n++;
                  cur = nxt;
                  steps++;
               end
            end
         end
         default: n = 0;
      endcase
      return n;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic dir_row_type dir_row(input logic [KIND_W-1:0] kind,
                                           input logic [KEY_W-1:0] hi,
                                           input logic [KEY_W-1:0] lo,
                                           input int reps, input bit typed,
                                           input table_rsp_type want);
      dir_row_type d;
      d.kind     = kind;
      d.key_high = hi;
      d.key_low  = lo;
      d.reps     = reps;
      d.typed    = typed;
      d.want     = want;
      return d;
   endfunction

   task automatic note_fail(input string what, input table_rsp_type want,
                            input table_rsp_type got);
      fail_cnt++;
      if (fail_cnt <= 10)
         $display("%0t %s: want st=%0d slot=%0d hi=%h lo=%h cnt=%0d last=%0d",
                  $time, what, want.status, want.slot, want.entry_high, want.entry_low,
                  want.count, want.last,
                  " | got st=%0d slot=%0d hi=%h lo=%h cnt=%0d last=%0d",
                  got.status, got.slot, got.entry_high,
                  got.entry_low, got.count, got.last);
   endtask

   // Present one request after a random gap and hold it until the transfer
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] hi,
                            input logic [KEY_W-1:0] lo, input bit typed,
                            input table_rsp_type want);
      int gap;
      gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_key_high <= hi;
      req_key_low  <= lo;
      drv_typed    <= typed;
      drv_want     <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off the sender until every outstanding response has arrived
   task automatic drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   // Stall the response side in runs, mostly short, with long ready stretches
   always @(posedge clock) begin
      if (ready_run != 0) begin
         ready_run <= ready_run - 1;
      end else if (rsp_ready && $urandom_range(0, 99) < 65) begin
         rsp_ready <= 1'b0;
         ready_run <= idle_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
         ready_run <= ($urandom_range(0, 99) < 80) ? $urandom_range(0, 7)
                                                   : $urandom_range(20, 60);
      end
   end

   // Check response transfers, then predict for request transfers
   always @(posedge clock) begin
      table_rsp_type got, want;
      int            n;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            key_hi_m[s] = '0;
            key_lo_m[s] = '0;
            link_m[s]   = 5'(s + 1);
         end
         head_m  = NO_LINK;
         free_m  = '0;
         count_m = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_slot, rsp_entry_high, rsp_entry_low, rsp_count, rsp_last};
            n_rsp++;
            if (got.status == STATUS_FULL) n_full++;
            if (got.status == STATUS_NOT_FOUND) n_miss++;
            if (got.status == STATUS_EMPTY) n_empty++;
            if (rsp_due.size() == 0) begin
               note_fail("response with none pending", '0, got);
            end else begin
               want = rsp_due.pop_front();
               if (got !== want) note_fail("response mismatch", want, got);
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind)
               KIND_ADD:    n_add++;
               KIND_REMOVE: n_remove++;
               KIND_WALK:   n_walk++;
               default:     n_unused++;
            endcase
            n = apply_table_op(req_kind, req_key_high, req_key_low);
            if (drv_typed) begin
               rsp_due.push_back(drv_want);
            end else begin
               for (int j = 0; j < n; j++) rsp_due.push_back(step_rsp[j]);
            end
         end
      end
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_cnt,
                  rsp_due.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      dir_row_type       rows [$];
      logic [127:0]      key_pool [$];
      logic [127:0]      key;
      logic [KIND_W-1:0] kind;
      int                r, seg, rnd_done;
      bit                fill_phase, paused;

      // directed corners: empty, single entries, full, misses, duplicates
      rows.push_back(dir_row(KIND_WALK, '0, '0, 1, 1'b1,
                             entry_rsp(STATUS_EMPTY, '0, '0, '0, 5'd0, 1'b1)));
      rows.push_back(dir_row(KIND_REMOVE, ONES, ONES, 1, 1'b1,
                             entry_rsp(STATUS_NOT_FOUND, '0, '0, '0, 5'd0, 1'b1)));
      rows.push_back(dir_row(KIND_UNUSED, ONES, ONES, 1, 1'b0, '0));
      rows.push_back(dir_row(KIND_ADD, ONES, ONES, 1, 1'b1,
                             entry_rsp(STATUS_OK, 4'd0, ONES, ONES, 5'd1, 1'b1)));
      rows.push_back(dir_row(KIND_ADD, '0, '0, 1, 1'b1,
                             entry_rsp(STATUS_OK, 4'd1, '0, '0, 5'd2, 1'b1)));
      rows.push_back(dir_row(KIND_ADD, FILL_HI, FILL_LO, 14, 1'b0, '0));
      rows.push_back(dir_row(KIND_ADD, MISS_HI, MISS_LO, 1, 1'b1,
                             entry_rsp(STATUS_FULL, '0, '0, '0, 5'd16, 1'b1)));
      rows.push_back(dir_row(KIND_WALK, '0, '0, 1, 1'b0, '0));
      rows.push_back(dir_row(KIND_REMOVE, FILL_HI + 7, FILL_LO - 7, 1, 1'b0, '0));
      rows.push_back(dir_row(KIND_REMOVE, ONES, ONES, 1, 1'b0, '0));
      rows.push_back(dir_row(KIND_REMOVE, MISS_HI, MISS_LO, 1, 1'b1,
                             entry_rsp(STATUS_NOT_FOUND, '0, '0, '0, 5'd14, 1'b1)));
      rows.push_back(dir_row(KIND_ADD, FILL_HI + 3, FILL_LO - 3, 1, 1'b0, '0));
      rows.push_back(dir_row(KIND_REMOVE, FILL_HI + 3, FILL_LO - 3, 1, 1'b0, '0));
      rows.push_back(dir_row(KIND_ADD, ONES, '0, 1, 1'b0, '0));
      rows.push_back(dir_row(KIND_REMOVE, '0, ONES, 1, 1'b1,
                             entry_rsp(STATUS_NOT_FOUND, '0, '0, '0, 5'd15, 1'b1)));
      rows.push_back(dir_row(KIND_WALK, '0, '0, 1, 1'b0, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         for (int k = 0; k < rows[i].reps; k++)
            send_item(rows[i].kind, rows[i].key_high + k, rows[i].key_low - k,
                      rows[i].typed, rows[i].want);

      // random traffic in alternating fill and drain phases
      rnd_done = 0;
      paused   = 1'b0;
      while (rnd_done < RANDOM_ITEMS) begin
         seg        = rnd_done / 30;
         fill_phase = (seg % 2) == 0;
         no_gaps    = (seg % 3) == 2;
         if (!paused && rnd_done == RANDOM_ITEMS / 2) begin
            drain_pause();
            paused = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < (fill_phase ? 55 : 20)) kind = KIND_ADD;
         else if (r < 75) kind = KIND_REMOVE;
         else if (r < 95) kind = KIND_WALK;
         else kind = KIND_UNUSED;
         key = {$urandom, $urandom, $urandom, $urandom};
         r = $urandom_range(0, 99);
         if (kind == KIND_ADD) begin
            if (r < 8 && key_pool.size() != 0)
               key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (r < 14)
               key = {($urandom_range(0, 1) != 0) ? ONES : 64'd0,
                      ($urandom_range(0, 1) != 0) ? ONES : 64'd0};
            key_pool.push_back(key);
            if (key_pool.size() > 32) void'(key_pool.pop_front());
         end else if (kind == KIND_REMOVE && r < 80 && key_pool.size() != 0) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end
         send_item(kind, key[127:64], key[63:0], 1'b0, '0);
         if (kind != KIND_UNUSED) rnd_done++;
      end

      drain_pause();
      repeat (40) @(posedge clock);
      if (rsp_due.size() != 0) note_fail("responses never arrived", rsp_due[0], '0);

      $display("Covered %0d adds, %0d removes, %0d walks, %0d ignored codes; %0d responses.",
               n_add, n_remove, n_walk, n_unused, n_rsp);
      $display("Full table %0d times, remove misses %0d, empty walks %0d, failures %0d.",
               n_full, n_miss, n_empty, fail_cnt);
      if (fail_cnt == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
